[sv/float_narrowing_convert_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the narrowing float converter
// Shared concurrent assertion forms, clocked on clk; FNC_ASSERT is held off during rst.
// ---------------------------------------------------------------------------
`ifndef FLOAT_NARROWING_CONVERT_DEFINES_SVH
`define FLOAT_NARROWING_CONVERT_DEFINES_SVH

// Implication or plain property, checked at every clock edge out of reset.
`define FNC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property that is also checked while reset is asserted.
`define FNC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/fnc_pkg.sv]
// ---------------------------------------------------------------------------
// fnc_pkg
// Types, constants and helpers shared by the narrowing float converter.
// ---------------------------------------------------------------------------
package fnc_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int FRAC_MAX    = 52;
  localparam int SIG_W       = FRAC_MAX + 1;
  localparam int EXP_FIELD_W = 11;
  localparam int EADJ_W      = 14;
  localparam int EB_W        = 12;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [2:0] REG_IN_EXP_BITS     = 3'd0;
  localparam logic [2:0] REG_IN_FRAC_BITS    = 3'd1;
  localparam logic [2:0] REG_OUT_EXP_BITS    = 3'd2;
  localparam logic [2:0] REG_OUT_FRAC_BITS   = 3'd3;
  localparam logic [2:0] REG_ROUND_MODE      = 3'd4;
  localparam logic [2:0] REG_FLUSH_SUBNORMAL = 3'd5;

  localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
  localparam logic [2:0] RM_TO_ZERO   = 3'd1;
  localparam logic [2:0] RM_DOWN      = 3'd2;
  localparam logic [2:0] RM_UP        = 3'd3;
  localparam logic [2:0] RM_NEAR_AWAY = 3'd4;

  typedef enum logic [1:0] {
    CLS_NAN,
    CLS_INF,
    CLS_ZERO,
    CLS_FINITE
  } cls_t;

  typedef struct packed {
    logic [3:0] ie;
    logic [5:0] ifr;
    logic [3:0] oe;
    logic [5:0] ofr;
    logic [2:0] rm;
    logic       flush;
  } cfg_t;

  typedef struct packed {
    logic                   sign;
    cls_t                   cls;
    logic [EXP_FIELD_W-1:0] ex;
    logic [FRAC_MAX-1:0]    fr;
    logic [5:0]             shl;
  } item_t;

  function automatic logic [11:0] mask12(input logic [3:0] n);
    return 12'((13'd1 << n) - 13'd1);
  endfunction

endpackage

[sv/fnc_front.sv]
// ---------------------------------------------------------------------------
// fnc_front
// Accepts input words, unpacks and classifies them, and finds the leading
// one of the fraction. One register stage toward the queue.
// ---------------------------------------------------------------------------
module fnc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  fnc_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fnc_pkg::WORD_WIDTH-1:0]    in_bits,
  output logic                              q_valid,
  input  logic                              q_ready,
  output fnc_pkg::item_t                    q_item
);

  logic           f_valid;
  fnc_pkg::item_t f_item;
  fnc_pkg::item_t item_next;

  logic [63:0]                        w64;
  logic [63:0]                        ex_all;
  logic [6:0]                         sign_pos;
  logic [11:0]                        ex_mask12;
  logic [fnc_pkg::EXP_FIELD_W-1:0]    ex_mask;
  logic [fnc_pkg::FRAC_MAX-1:0]       fr_mask;
  logic [5:0]                         lead;

  always_comb begin
    w64       = {32'd0, in_bits};
    sign_pos  = 7'(cfg.ie) + 7'(cfg.ifr);
    ex_all    = w64 >> cfg.ifr;
    ex_mask12 = fnc_pkg::mask12(cfg.ie);
    ex_mask   = ex_mask12[fnc_pkg::EXP_FIELD_W-1:0];
    fr_mask   = 52'((53'd1 << cfg.ifr) - 53'd1);
    item_next.sign = w64[sign_pos[5:0]];
    item_next.ex   = ex_all[fnc_pkg::EXP_FIELD_W-1:0] & ex_mask;
    item_next.fr   = w64[fnc_pkg::FRAC_MAX-1:0] & fr_mask;
    lead = 6'd0;
    for (int k = 0; k < fnc_pkg::FRAC_MAX; k++) begin
      if (item_next.fr[k]) begin
        lead = 6'(k);
      end
    end
    item_next.shl = cfg.ifr - lead;
    if (item_next.ex == ex_mask) begin
      item_next.cls = (item_next.fr != '0) ? fnc_pkg::CLS_NAN : fnc_pkg::CLS_INF;
    end else if (item_next.ex == '0 && item_next.fr == '0) begin
      item_next.cls = fnc_pkg::CLS_ZERO;
    end else begin
      item_next.cls = fnc_pkg::CLS_FINITE;
    end
  end

  assign in_ready = !f_valid || q_ready;
  assign q_valid  = f_valid;
  assign q_item   = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item <= item_next;
    end
  end

endmodule

[sv/fnc_queue.sv]
// ---------------------------------------------------------------------------
// fnc_queue
// Short queue between the front and back parts so each can stall alone.
// ---------------------------------------------------------------------------
`include "float_narrowing_convert_defines.svh"

module fnc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fnc_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fnc_pkg::item_t  pop_item
);

  fnc_pkg::item_t              slots [fnc_pkg::QUEUE_DEPTH];
  logic [fnc_pkg::QPTR_W-1:0]  wptr;
  logic [fnc_pkg::QPTR_W-1:0]  rptr;
  logic [fnc_pkg::QCNT_W-1:0]  count;
  logic                        push;
  logic                        pop;

  assign push_ready = count != fnc_pkg::QCNT_W'(fnc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  `FNC_ASSERT(a_count_max, count <= fnc_pkg::QCNT_W'(fnc_pkg::QUEUE_DEPTH), "queue overfilled")
  `FNC_ASSERT(a_count_up, (push && !pop) |=> count == $past(count) + 1'b1, "count missed push")
  `FNC_ASSERT(a_count_down, (pop && !push) |=> count == $past(count) - 1'b1, "count missed pop")

endmodule

[sv/fnc_back.sv]
// ---------------------------------------------------------------------------
// fnc_back
// Aligns the significand, shifts subnormal results, rounds and packs.
// Three register stages, the last of which is the output register.
// ---------------------------------------------------------------------------
`include "float_narrowing_convert_defines.svh"

module fnc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  fnc_pkg::cfg_t                  cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fnc_pkg::item_t                 in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fnc_pkg::WORD_WIDTH-1:0] out_bits,
  output logic                           invalid,
  output logic                           overflow,
  underflow
);

  // stage A: aligned significand and adjusted exponent
  logic                              a_valid;
  logic                              a_sign;
  fnc_pkg::cls_t                     a_cls;
  logic [fnc_pkg::SIG_W-1:0]         a_sig;
  logic signed [fnc_pkg::EADJ_W-1:0] a_e;
  // stage B: subnormal shift done
  logic                              b_valid;
  logic                              b_sign;
  fnc_pkg::cls_t                     b_cls;
  logic [fnc_pkg::SIG_W-1:0]         b_sig;
  logic [fnc_pkg::EB_W-1:0]          b_e;

  logic a_adv, b_adv, o_adv;

  logic [fnc_pkg::SIG_W-1:0]         sig_n;
  logic signed [fnc_pkg::EADJ_W-1:0] e_n;
  logic [5:0]                        sh;
  logic [fnc_pkg::SIG_W-1:0]         sig_al;
  logic signed [fnc_pkg::EADJ_W-1:0] e_adj;

  logic [fnc_pkg::EADJ_W-1:0]        nshift;
  logic [fnc_pkg::SIG_W-1:0]         dmask;
  logic [fnc_pkg::SIG_W-1:0]         sig_b_next;
  logic [fnc_pkg::EB_W-1:0]          e_b_next;

  logic                              lb, rb, sb, inc, carry, ovf, unf;
  logic [fnc_pkg::SIG_W-2:0]         m1;
  logic [fnc_pkg::SIG_W-2:0]         msig;
  logic [12:0]                       e_c;
  logic [11:0]                       emax;
  logic [5:0]                        pos;
  logic [63:0]                       res;
  logic [63:0]                       oe_field;
  logic [fnc_pkg::WORD_WIDTH-1:0]    out_next;

  assign o_adv    = !out_valid || out_ready;
  assign b_adv    = !b_valid || o_adv;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  always_comb begin
    if (in_item.ex == '0) begin
      sig_n = fnc_pkg::SIG_W'(in_item.fr) << in_item.shl;
      e_n   = fnc_pkg::EADJ_W'(1) - fnc_pkg::EADJ_W'(in_item.shl);
    end else begin
      sig_n = fnc_pkg::SIG_W'(in_item.fr) | (fnc_pkg::SIG_W'(1) << cfg.ifr);
      e_n   = fnc_pkg::EADJ_W'(in_item.ex);
    end
    sh     = cfg.ifr - cfg.ofr - 6'd2;
    sig_al = (sig_n >> sh)
           | fnc_pkg::SIG_W'((sig_n & ((fnc_pkg::SIG_W'(1) << sh) - 1'b1)) != '0);
    e_adj  = e_n + fnc_pkg::EADJ_W'(fnc_pkg::mask12(cfg.oe - 4'd1))
           - fnc_pkg::EADJ_W'(fnc_pkg::mask12(cfg.ie - 4'd1)) - fnc_pkg::EADJ_W'(1);
  end

  always_comb begin
    nshift     = fnc_pkg::EADJ_W'(-a_e);
    dmask      = ~({fnc_pkg::SIG_W{1'b1}} << nshift);
    sig_b_next = a_sig;
    e_b_next   = a_e[fnc_pkg::EB_W-1:0];
    if (a_e < 0) begin
      e_b_next = '0;
      if (nshift >= fnc_pkg::EADJ_W'(64)) begin
        sig_b_next = fnc_pkg::SIG_W'(a_sig != '0);
      end else begin
        sig_b_next = (a_sig >> nshift) | fnc_pkg::SIG_W'((a_sig & dmask) != '0);
      end
    end
  end

  always_comb begin
    lb = b_sig[2];
    rb = b_sig[1];
    sb = b_sig[0];
    case (cfg.rm)
      fnc_pkg::RM_TO_ZERO:   inc = 1'b0;
      fnc_pkg::RM_DOWN:      inc = b_sign && (rb || sb);
      fnc_pkg::RM_UP:        inc = !b_sign && (rb || sb);
      fnc_pkg::RM_NEAR_AWAY: inc = rb;
      default:               inc = rb && (lb || sb);
    endcase
    m1    = b_sig[fnc_pkg::SIG_W-1:2] + (fnc_pkg::SIG_W-1)'(inc);
    carry = m1[cfg.ofr + 6'd1];
    msig  = carry ? (m1 >> 1) : m1;
    e_c   = 13'(b_e) + 13'(carry);
    emax  = fnc_pkg::mask12(cfg.oe) - 12'd1;
    ovf   = 1'b0;
    if (e_c >= 13'(emax)) begin
      msig = '0;
      e_c  = 13'(emax) + 13'd1;
      ovf  = 1'b1;
    end
    unf      = (rb || sb) && e_c == '0 && msig == '0;
    pos      = cfg.oe + cfg.ofr;
    oe_field = 64'(fnc_pkg::mask12(cfg.oe)) << cfg.ofr;
    res      = ((64'(b_sign) << pos) | (64'(e_c) << cfg.ofr)) + 64'(msig);
    if (ovf && (cfg.rm == fnc_pkg::RM_TO_ZERO || (b_sign && cfg.rm == fnc_pkg::RM_UP)
                || (!b_sign && cfg.rm == fnc_pkg::RM_DOWN))) begin
      res = res - 64'd1;
    end
    if (cfg.flush && ((res & oe_field) == '0)) begin
      res = 64'(b_sign) << pos;
    end
    case (b_cls)
      fnc_pkg::CLS_NAN: begin
        res = oe_field | (64'd1 << (cfg.ofr - 6'd1));
        ovf = 1'b0;
        unf = 1'b0;
      end
      fnc_pkg::CLS_INF: begin
        res = (64'(b_sign) << pos) | oe_field;
        ovf = 1'b0;
        unf = 1'b0;
      end
      fnc_pkg::CLS_ZERO: begin
        res = 64'(b_sign) << pos;
        ovf = 1'b0;
        unf = 1'b0;
      end
      default: begin
      end
    endcase
    out_next = res[fnc_pkg::WORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid <= in_valid;
      end
      if (b_adv) begin
        b_valid <= a_valid;
      end
      if (o_adv) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && in_valid) begin
      a_sign <= in_item.sign;
      a_cls  <= in_item.cls;
      a_sig  <= sig_al;
      a_e    <= e_adj;
    end
    if (b_adv && a_valid) begin
      b_sign <= a_sign;
      b_cls  <= a_cls;
      b_sig  <= sig_b_next;
      b_e    <= e_b_next;
    end
    if (o_adv && b_valid) begin
      out_bits  <= out_next;
      invalid   <= b_cls == fnc_pkg::CLS_NAN;
      overflow  <= ovf;
      underflow <= unf;
    end
  end

  `FNC_ASSERT(a_nan_flags, out_valid && invalid |-> !overflow && !underflow, "NaN with range flag")
  `FNC_ASSERT(a_flags_excl, out_valid |-> !(overflow && underflow), "overflow and underflow")
  `FNC_ASSERT(a_b_hold, b_valid && !b_adv |=> b_valid && $stable(b_sig) && $stable(b_e), "stage B lost")

endmodule

[sv/float_narrowing_convert.sv]
// ---------------------------------------------------------------------------
// float_narrowing_convert
// Converts a float in a configurable wide format into a narrower format
// with five rounding modes, range flags and optional subnormal flush.
// ---------------------------------------------------------------------------
//   channel  signals                         transfer when
//   in       in_valid in_ready in_bits       in_valid && in_ready
//   out      out_valid out_ready out_bits..  out_valid && out_ready
//   cfg      cfg_write cfg_index cfg_data    cfg_write
//
// One item per cycle is sustained while the output is not stalled; each
// transfer in passes through the front register, queue, two back stages and the
// output register. Reset loads the register defaults and empties all stages.
// A stall at the output fills the back stages and then the two-entry queue
// before the input stops taking transfers.
// ---------------------------------------------------------------------------
module float_narrowing_convert (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [2:0]                     cfg_index,
  input  logic [5:0]                     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fnc_pkg::WORD_WIDTH-1:0] in_bits,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fnc_pkg::WORD_WIDTH-1:0] out_bits,
  output logic                           invalid,
  output logic                           overflow,
  output logic                           underflow
);

  logic [3:0] in_exp_bits;
  logic [5:0] in_frac_bits;
  logic [3:0] out_exp_bits;
  logic [5:0] out_frac_bits;
  logic [2:0] round_mode;
  logic       flush_subnormal;

  fnc_pkg::cfg_t  cfg;
  logic [5:0]     ofr_c;
  logic           f_valid;
  logic           q_push_ready;
  fnc_pkg::item_t f_item;
  logic           q_valid;
  logic           b_ready;
  fnc_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_exp_bits     <= 4'd8;
      in_frac_bits    <= 6'd23;
      out_exp_bits    <= 4'd5;
      out_frac_bits   <= 6'd10;
      round_mode      <= fnc_pkg::RM_NEAR_EVEN;
      flush_subnormal <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        fnc_pkg::REG_IN_EXP_BITS:     in_exp_bits     <= cfg_data[3:0];
        fnc_pkg::REG_IN_FRAC_BITS:    in_frac_bits    <= cfg_data;
        fnc_pkg::REG_OUT_EXP_BITS:    out_exp_bits    <= cfg_data[3:0];
        fnc_pkg::REG_OUT_FRAC_BITS:   out_frac_bits   <= cfg_data;
        fnc_pkg::REG_ROUND_MODE:      round_mode      <= cfg_data[2:0];
        fnc_pkg::REG_FLUSH_SUBNORMAL: flush_subnormal <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.ie  = (in_exp_bits < 4'd2) ? 4'd2 : (in_exp_bits > 4'd11) ? 4'd11 : in_exp_bits;
    cfg.ifr = (in_frac_bits < 6'd4) ? 6'd4
            : (in_frac_bits > 6'd52) ? 6'd52 : in_frac_bits;
    cfg.oe  = (out_exp_bits < 4'd2) ? 4'd2
            : (out_exp_bits > 4'd11) ? 4'd11 : out_exp_bits;
    ofr_c   = (out_frac_bits < 6'd1) ? 6'd1
            : (out_frac_bits > 6'd49) ? 6'd49 : out_frac_bits;
    cfg.ofr = (ofr_c > cfg.ifr - 6'd3) ? cfg.ifr - 6'd3 : ofr_c;
    cfg.rm  = (round_mode > fnc_pkg::RM_NEAR_AWAY) ? fnc_pkg::RM_NEAR_EVEN : round_mode;
    cfg.flush = flush_subnormal;
  end

  fnc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_bits  (in_bits),
    .q_valid  (f_valid),
    .q_ready  (q_push_ready),
    .q_item   (f_item)
  );

  fnc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_push_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (b_ready),
    .pop_item   (q_item)
  );

  fnc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_ready  (b_ready),
    .in_item   (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_bits  (out_bits),
    .invalid   (invalid),
    .overflow  (overflow),
    .underflow (underflow)
  );

endmodule
